FILE: rtl/atan2p_pkg.sv
package atan2p_pkg;

	localparam int QBITS      = 18;
	localparam int R_W        = QBITS + 1;     // ratio, 0 .. 2^18
	localparam int ACC_W      = 21;            // Horner accumulator, signed Q18
	localparam int V_W        = 22;            // angle before output, signed Q18
	localparam int DIV_STAGES = QBITS + 1;     // one quotient bit per stage
	localparam int HORNER_N   = 7;
	localparam int ANGLE_W    = 16;

	localparam logic signed [V_W-1:0] Q_HALF_PI = 22'sd411775;
	localparam logic signed [V_W-1:0] Q_PI      = 22'sd823550;

	localparam logic signed [ACC_W-1:0] COEF [HORNER_N] = '{
		21'sd1891, -21'sd9191, 21'sd21411, -21'sd35061,
		21'sd52053, -21'sd87359, 21'sd262144
	};

	// octant and special-case flags that ride along with the data
	typedef struct packed {
		logic y_neg;
		logic x_neg;
		logic y_big;
		logic zero;
	} side_t;

endpackage

FILE: rtl/atan2p_div.sv
module atan2p_div #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic [atan2p_pkg::DIV_STAGES-1:0]     adv,
	input  logic [COORD_WIDTH-1:0]                small_in,
	input  logic [COORD_WIDTH-1:0]                big_in,
	input  atan2p_pkg::side_t                     side_in,
	output logic [atan2p_pkg::R_W-1:0]            ratio,
	output atan2p_pkg::side_t                     side_out
);
	import atan2p_pkg::*;

	logic [COORD_WIDTH-1:0] rem_s  [DIV_STAGES];
	logic [COORD_WIDTH-1:0] big_s  [DIV_STAGES];
	logic [R_W-1:0]         quo_s  [DIV_STAGES];
	side_t                  side_s [DIV_STAGES];

	// first step: quotient MSB is set when small is at least big (equal, as small never exceeds big)
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			if (small_in >= big_in) begin
				rem_s[0] <= small_in - big_in;
				quo_s[0] <= R_W'(1) << QBITS;
			end else begin
				rem_s[0] <= small_in;
				quo_s[0] <= '0;
			end
			big_s[0]  <= big_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 1; i < DIV_STAGES; i++) begin : g_step
		logic [COORD_WIDTH:0] trial;
		logic                 ge;
		assign trial = {rem_s[i-1], 1'b0};
		assign ge    = trial >= {1'b0, big_s[i-1]};
		always_ff @(posedge clk) begin
			if (adv[i]) begin
				rem_s[i]  <= ge ? COORD_WIDTH'(trial - {1'b0, big_s[i-1]})
				                : COORD_WIDTH'(trial);
				quo_s[i]  <= quo_s[i-1] | (R_W'(ge) << (QBITS - i));
				big_s[i]  <= big_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign ratio    = quo_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

FILE: rtl/atan2_polynomial_top.sv
// atan2_polynomial_top: four-quadrant arctangent, one coordinate pair per clock while m_tready is high.
//
// Input channel s_*: tdata carries y_value (low COORD_WIDTH bits) and
// x_value (next COORD_WIDTH bits), both two's complement. Output channel m_*:
// tdata carries angle in radians, signed, ANGLE_FRAC_BITS fraction bits.
//
// Throughput: one transaction per cycle in and out while m_tready is high.
// Pipeline: 28 register stages; the accepting edge itself loads the first
// stage, and m_tvalid rises once the item reaches the output stage.
// Stages: 19 divider stages (one quotient bit each), one for r^2, six
// Horner stages, one for the final multiply by r and one output stage for
// octant fold-back and rounding.
//
// Each stage has its own valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles collapse and a stalled receiver holds
// the result in the output stage while upstream stages keep filling.
// s_tready drops only once every stage holds an item.
//
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers
// are not reset. Both coordinates zero gives angle 0.
module atan2_polynomial_top #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// bits from lowest: y_value, x_value, zero pad
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// bits from lowest: angle
	output logic [atan2p_pkg::ANGLE_W-1:0]            m_tdata
);
	import atan2p_pkg::*;

	localparam int NSTG  = DIV_STAGES + HORNER_N + 2;  // total stages
	localparam int PB    = DIV_STAGES;                  // first polynomial stage
	localparam int SH_R  = (ANGLE_FRAC_BITS < QBITS) ? QBITS - ANGLE_FRAC_BITS : 0;
	localparam int SH_L  = (ANGLE_FRAC_BITS < QBITS) ? 0 : ANGLE_FRAC_BITS - QBITS;
	localparam logic [47:0] RND = (ANGLE_FRAC_BITS < QBITS) ?
		(48'd1 << ((ANGLE_FRAC_BITS < QBITS) ? SH_R - 1 : 0)) : 48'd0;

	// ---- stage control: valid bits and the advance chain ----
	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   adv;

	assign adv[NSTG] = m_tready;
	for (genvar k = 0; k < NSTG; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld_q[NSTG-1];

	// ---- magnitudes and octant ----
	logic signed [COORD_WIDTH-1:0] y_in, x_in;
	logic [COORD_WIDTH-1:0]        ay, ax, small_v, big_v;
	side_t                         side_in;

	assign y_in = s_tdata[COORD_WIDTH-1:0];
	assign x_in = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign ay   = y_in[COORD_WIDTH-1] ? COORD_WIDTH'(-y_in) : COORD_WIDTH'(y_in);
	assign ax   = x_in[COORD_WIDTH-1] ? COORD_WIDTH'(-x_in) : COORD_WIDTH'(x_in);

	always_comb begin
		side_in.y_neg = y_in[COORD_WIDTH-1];
		side_in.x_neg = x_in[COORD_WIDTH-1];
		side_in.y_big = ay > ax;
		big_v   = side_in.y_big ? ay : ax;
		small_v = side_in.y_big ? ax : ay;
		side_in.zero  = (big_v == '0);
	end

	// ---- ratio = floor(small * 2^18 / big) ----
	logic [R_W-1:0] ratio;
	side_t          side_div;

	atan2p_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
		.clk      (clk),
		.adv      (adv[DIV_STAGES-1:0]),
		.small_in (small_v),
		.big_in   (big_v),
		.side_in  (side_in),
		.ratio    (ratio),
		.side_out (side_div)
	);

	// ---- polynomial: index 0 holds r^2, 1..6 the Horner steps ----
	logic signed [ACC_W-1:0] acc_s  [HORNER_N];
	logic [R_W-1:0]          r_s    [HORNER_N];
	logic [R_W-1:0]          r2_s   [HORNER_N];
	side_t                   side_s [HORNER_N];

	logic [2*R_W-1:0] rr;
	assign rr = ratio * ratio + (2*R_W)'(1 << (QBITS - 1));

	always_ff @(posedge clk) begin
		if (adv[PB]) begin
			r2_s[0]   <= R_W'(rr >> QBITS);
			r_s[0]    <= ratio;
			acc_s[0]  <= COEF[0];
			side_s[0] <= side_div;
		end
	end

	for (genvar h = 1; h < HORNER_N; h++) begin : g_horner
		logic signed [ACC_W+R_W:0] prod;
		assign prod = acc_s[h-1] * $signed({1'b0, r2_s[h-1]})
		            + (ACC_W+R_W+1)'(1 << (QBITS - 1));
		always_ff @(posedge clk) begin
			if (adv[PB+h]) begin
				acc_s[h]  <= ACC_W'(prod >>> QBITS) + COEF[h];
				r_s[h]    <= r_s[h-1];
				r2_s[h]   <= r2_s[h-1];
				side_s[h] <= side_s[h-1];
			end
		end
	end

	// ---- v = acc * r ----
	logic signed [ACC_W+R_W:0] vprod;
	logic signed [V_W-1:0]     v_s7;
	side_t                     side_s7;

	assign vprod = acc_s[HORNER_N-1] * $signed({1'b0, r_s[HORNER_N-1]})
	             + (ACC_W+R_W+1)'(1 << (QBITS - 1));

	always_ff @(posedge clk) begin
		if (adv[PB+HORNER_N]) begin
			v_s7    <= V_W'(vprod >>> QBITS);
			side_s7 <= side_s[HORNER_N-1];
		end
	end

	// ---- octant fold-back, rounding to output scale, sign ----
	logic signed [V_W-1:0] v1, v2;
	logic [47:0]           vw, mag;
	logic [ANGLE_W-1:0]    ang;

	always_comb begin
		v1 = side_s7.y_big ? Q_HALF_PI - v_s7 : v_s7;
		v2 = side_s7.x_neg ? Q_PI - v1 : v1;
		vw = v2[V_W-1] ? 48'd0 : 48'(v2);
		if (ANGLE_FRAC_BITS < QBITS) mag = (vw + RND) >> SH_R;
		else                         mag = vw << SH_L;
		ang = side_s7.y_neg ? ANGLE_W'(48'd0 - mag) : ANGLE_W'(mag);
		if (side_s7.zero) ang = '0;
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) m_tdata <= ang;
	end

endmodule

FILE: rtl/atan2p_checker.sv
module atan2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a held result stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// a held result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// empty output stage means no stage can be full-blocked
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind atan2_polynomial_top atan2p_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import atan2p_pkg::*;

	localparam int CW = 16;
	localparam int AFB = 13;
	localparam int DW = ((2*CW+7)/8)*8;
	localparam int PIPE_LAT = 28;
	localparam int N_RANDOM = 1100;

	// Q18 constants of the polynomial and the octant fold
	localparam longint Q_HALF = 64'sd131072;
	localparam longint HALF_PI_Q = 64'sd411775;
	localparam longint PI_Q = 64'sd823550;
	localparam longint ATAN_COEF [7] = '{
		1891, -9191, 21411, -35061, 52053, -87359, 262144
	};

	// angle codes that can be read off without the polynomial
	localparam logic [15:0] ANG_ZERO = 16'd0;
	localparam logic [15:0] ANG_PI = 16'd25736;
	localparam logic [15:0] ANG_HALF_PI = 16'd12868;
	localparam logic [15:0] ANG_NEG_HALF_PI = 16'hcdbc;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DW-1:0] s_tdata;     // bits from lowest: y_value, x_value
	logic m_tvalid;
	logic m_tready;
	logic [ANGLE_W-1:0] m_tdata; // bits from lowest: angle

	atan2_polynomial_top #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(AFB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// expected angles, oldest first
	logic [15:0] angle_fifo [$];
	int mismatches = 0;
	int n_checked = 0;
	int n_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stim_done = 0;

	// directed rows: y, x, typed-in angle where obvious
	typedef struct {
		logic signed [15:0] y;
		logic signed [15:0] x;
		bit has_angle;
		logic [15:0] angle;
	} pair_row_t;

	pair_row_t pair_rows [] = '{
		'{16'sd0, 16'sd0, 1, ANG_ZERO},
		'{16'sd0, 16'sd100, 1, ANG_ZERO},
		'{16'sd0, -16'sd1, 1, ANG_PI},
		'{16'sd0, -16'sd32768, 1, ANG_PI},
		'{16'sd32767, 16'sd0, 1, ANG_HALF_PI},
		'{-16'sd32768, 16'sd0, 1, ANG_NEG_HALF_PI},
		'{16'sd1, 16'sd1, 0, 16'd0},
		'{-16'sd1, -16'sd1, 0, 16'd0},
		'{-16'sd32768, -16'sd32768, 0, 16'd0},
		'{16'sd32767, -16'sd32768, 0, 16'd0},
		'{-16'sd32768, 16'sd32767, 0, 16'd0},
		'{16'sd32767, 16'sd32767, 0, 16'd0},
		'{16'sd1, 16'sd32767, 0, 16'd0},
		'{-16'sd1, -16'sd32768, 0, 16'd0},
		'{16'sd32767, 16'sd1, 0, 16'd0},
		'{-16'sd32767, -16'sd1, 0, 16'd0},
		'{16'sd12345, -16'sd23456, 0, 16'd0},
		'{-16'sd5, 16'sd3, 0, 16'd0},
		'{16'sd21845, 16'sd32767, 0, 16'd0},
		'{-16'sd32767, 16'sd32766, 0, 16'd0}
	};

	// Q18 product, ties toward plus infinity (arithmetic shift is floor)
	function automatic longint q18_mul(longint a, longint b);
		return (a * b + Q_HALF) >>> 18;
	endfunction

	function automatic logic [15:0] predict_angle(logic signed [15:0] y,
			logic signed [15:0] x);
		longint ay, ax, big, lesser, ratio, ratio_sq, horner, v, mag;
		bit y_big;
		ay = (y < 0) ? -longint'(y) : longint'(y);
		ax = (x < 0) ? -longint'(x) : longint'(x);
		y_big = ay > ax;
		big = y_big ? ay : ax;
		lesser = y_big ? ax : ay;
		if (big == 0)
			return 16'd0;
		ratio = (lesser <<< 18) / big;
		ratio_sq = q18_mul(ratio, ratio);
		horner = ATAN_COEF[0];
		for (int k = 1; k < 7; k++)
			horner = q18_mul(horner, ratio_sq) + ATAN_COEF[k];
		v = q18_mul(horner, ratio);
		if (y_big)
			v = HALF_PI_Q - v;
		if (x < 0)
			v = PI_Q - v;
		if (v < 0)
			v = 0;
		// round Q18 magnitude to output fraction, then apply sign
		mag = (v + (64'sd1 <<< (17 - AFB))) >>> (18 - AFB);
		if (y < 0)
			mag = -mag;
		return mag[15:0];
	endfunction

	// clock, period 4 ns
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// send one transaction; inputs change on the falling edge
	task automatic send_pair(logic signed [15:0] y, logic signed [15:0] x,
			bit has_angle, logic [15:0] angle);
		logic [15:0] predicted;
		predicted = predict_angle(y, x);
		if (has_angle && predicted != angle) begin
			// predictor disagrees with a hand-typed row: flag it
			mismatches++;
			if (mismatches <= 10)
				$display("table row y=%0d x=%0d: typed %h, predicted %h",
					y, x, angle, predicted);
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= DW'({x, y});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		angle_fifo.push_back(has_angle ? angle : predicted);
		n_sent++;
		@(negedge clk);
	endtask

	// random pair: mostly full range, some near axes/diagonals and small values
	task automatic send_random_pair();
		logic signed [15:0] y, x;
		int kind;
		kind = $urandom_range(9);
		y = 16'($urandom);
		x = 16'($urandom);
		if (kind == 0) begin
			y = $signed(16'($urandom_range(7))) - 16'sd4;
		end else if (kind == 1) begin
			x = $signed(16'($urandom_range(7))) - 16'sd4;
		end else if (kind == 2) begin
			x = ($urandom_range(1)) ? y : -y;
		end else if (kind == 3) begin
			y = $signed(16'($urandom_range(64))) - 16'sd32;
			x = $signed(16'($urandom_range(64))) - 16'sd32;
		end
		send_pair(y, x, 0, 16'd0);
	endtask

	// receiver: stalls at random, checks at the rising edge
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		else
			m_tready <= 0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_fifo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction, angle %h", m_tdata);
			end else begin
				logic [15:0] expected_angle;
				expected_angle = angle_fifo.pop_front();
				n_checked++;
				if (m_tdata !== expected_angle) begin
					mismatches++;
					if (mismatches <= 10)
						$display("angle mismatch: expected %h, got %h",
							expected_angle, m_tdata);
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (pair_rows[i])
			send_pair(pair_rows[i].y, pair_rows[i].x,
				pair_rows[i].has_angle, pair_rows[i].angle);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 64 : 0;
			recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 30 : 0;
			for (int i = 0; i < N_RANDOM / 3; i++)
				send_random_pair();
			// hold off until the pipeline has drained once
			if (phase == 0) begin
				s_tvalid <= 0;
				@(negedge clk);
				while (angle_fifo.size() != 0)
					@(negedge clk);
			end
		end
		s_tvalid <= 0;
		stim_done = 1;
	end

	// end of run
	initial begin
		wait (stim_done);
		while (angle_fifo.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT * 2) @(posedge clk);
		$display("sent %0d coordinate pairs (all quadrants, axes, diagonals, extremes)",
			n_sent);
		$display("checked %0d angles under three stall mixes, %0d mismatches",
			n_checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/atan2p_pkg.sv
rtl/atan2p_div.sv
rtl/atan2_polynomial_top.sv
rtl/atan2p_checker.sv
tb/sv/tb_top.sv
